[hw/rtl/ens_pkg.sv]
// Shared constants for the eight-neighbour mean stencil.
// Register indexes, reset values and fixed field widths; no dependencies.
package ens_pkg;

  localparam int unsigned CFG_IDX_BITS  = 8;
  localparam int unsigned CFG_DATA_BITS = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 8'd1;

  localparam int unsigned FW_BITS   = 13;
  localparam int unsigned ROW_BITS  = 16;
  localparam int unsigned MEAN_BITS = 19;

  localparam logic [FW_BITS-1:0]  FRAME_WIDTH_RST  = 13'd640;
  localparam logic [ROW_BITS-1:0] FRAME_HEIGHT_RST = 16'd480;

  // Smallest usable frame side
  localparam int unsigned MIN_SIDE = 3;

endpackage

[hw/rtl/eight_neighbour_mean_stencil.sv]
// Eight-neighbour 3x3 mean over a row-major sample stream.
// Channels:
//   s_axis: one sample word per transfer, row-major, frame after frame.
//   m_axis: one result word per interior centre (not on an outer row or
//           column): centre row, centre column and the sum of the eight
//           neighbours, read as unsigned fixed point with three fraction
//           bits. tlast marks the last interior result of a frame.
//   cfg:    write-only register port, always ready. A write to frame_width
//           or frame_height restarts the frame at row 0, column 0; write
//           only while the block is idle.
// Throughput: one sample per cycle while the receiver takes results. Each
// sample reads both line stores at its column on acceptance and writes them
// back when it leaves the input stage, so each store needs one read and one
// write port per cycle to keep that rate. A result passes from the input
// stage into the output register, where it is shown on m_axis.
// Reset clears counters, window and valid flags; line stores are not
// cleared and are filled by the first two rows of a frame. When the
// receiver stalls, the output word holds and one more sample is held in the
// input stage, then s_axis_tready_o drops.
// Depends on ens_pkg and ens_ram.
module eight_neighbour_mean_stencil
  import ens_pkg::*;
#(
  parameter int unsigned MAX_WIDTH   = 4096,
  parameter int unsigned SAMPLE_BITS = 16,
  localparam int unsigned COL_BITS = $clog2(MAX_WIDTH),
  localparam int unsigned IN_W     = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_BITS = ROW_BITS + COL_BITS + MEAN_BITS,
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // s_axis_tdata_i: [SAMPLE_BITS-1:0] sample
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  logic [IN_W-1:0]          s_axis_tdata_i,
  // m_axis_tdata_o: centre_row, centre_col, neighbour_mean (low bits up)
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  output logic [OUT_W-1:0]         m_axis_tdata_o,
  output logic                     m_axis_tlast_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  localparam int unsigned SUM_BITS = SAMPLE_BITS + 3;

  // Configuration
  logic [FW_BITS-1:0]  frame_width_q;
  logic [ROW_BITS-1:0] frame_height_q;
  logic                cfg_wr;
  logic                cfg_hit;
  logic [31:0]         w_eff;
  logic [COL_BITS-1:0] col_last;
  logic [ROW_BITS-1:0] row_last;

  // Position of the next sample
  logic [COL_BITS-1:0] col_q, col_d;
  logic [ROW_BITS-1:0] row_q, row_d;

  // Input stage
  logic                   a_valid_q, a_valid_d;
  logic [SAMPLE_BITS-1:0] a_sample_q;
  logic [COL_BITS-1:0]    a_col_q;
  logic [ROW_BITS-1:0]    a_row_q;
  logic                   a_emit_q;
  logic                   a_last_q;

  // Window: [0..2] column c-2 (top, mid, bot), [3..5] column c-1
  logic [SAMPLE_BITS-1:0] win_q [6];

  // Output register
  logic                   out_valid_q, out_valid_d;
  logic [ROW_BITS-1:0]    out_row_q;
  logic [COL_BITS-1:0]    out_col_q;
  logic [MEAN_BITS-1:0]   out_mean_q;
  logic                   out_last_q;

  logic                   accept;
  logic                   advance;
  logic                   out_free;
  logic [SAMPLE_BITS-1:0] top_rd;
  logic [SAMPLE_BITS-1:0] mid_rd;
  logic [SUM_BITS-1:0]    sum;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i;
  assign cfg_hit     = cfg_wr &&
                       (cfg_index_i == REG_FRAME_WIDTH || cfg_index_i == REG_FRAME_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
    end else if (cfg_wr) begin
      case (cfg_index_i)
        REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[FW_BITS-1:0];
        REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[ROW_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the frame width to the usable range
  always_comb begin
    if (32'(frame_width_q) < MIN_SIDE) begin
      w_eff = MIN_SIDE;
    end else if (32'(frame_width_q) > MAX_WIDTH) begin
      w_eff = MAX_WIDTH;
    end else begin
      w_eff = 32'(frame_width_q);
    end
  end

  assign col_last = COL_BITS'(w_eff - 32'd1);
  assign row_last = (32'(frame_height_q) < MIN_SIDE) ? ROW_BITS'(MIN_SIDE - 1)
                                                     : frame_height_q - 1'b1;

  // Handshake
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign advance         = a_valid_q && (!a_emit_q || out_free);
  assign s_axis_tready_o = !a_valid_q || advance;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_hit) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (col_q == col_last) begin
        col_d = '0;
        row_d = (row_q == row_last) ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_comb begin
    a_valid_d = a_valid_q;
    if (accept) begin
      a_valid_d = 1'b1;
    end else if (advance) begin
      a_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      a_valid_q <= 1'b0;
    end else begin
      col_q     <= col_d;
      row_q     <= row_d;
      a_valid_q <= a_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_sample_q <= s_axis_tdata_i[SAMPLE_BITS-1:0];
      a_col_q    <= col_q;
      a_row_q    <= row_q;
      a_emit_q   <= (row_q >= ROW_BITS'(2)) && (col_q >= COL_BITS'(2));
      a_last_q   <= (row_q == row_last) && (col_q == col_last);
    end
  end

  // Line stores: read at the column on accept, write back when the word advances
  ens_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_upper (
    .clk_i   (clk_i),
    .we_i    (advance),
    .waddr_i (a_col_q),
    .wdata_i (mid_rd),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (top_rd)
  );

  ens_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_middle (
    .clk_i   (clk_i),
    .we_i    (advance),
    .waddr_i (a_col_q),
    .wdata_i (a_sample_q),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (mid_rd)
  );

  // Neighbour sum, centre (window slot 4) left out
  assign sum = SUM_BITS'(win_q[0]) + SUM_BITS'(win_q[1]) + SUM_BITS'(win_q[2])
             + SUM_BITS'(win_q[3]) + SUM_BITS'(win_q[5])
             + SUM_BITS'(top_rd) + SUM_BITS'(mid_rd) + SUM_BITS'(a_sample_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (advance) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= top_rd;
      win_q[4] <= mid_rd;
      win_q[5] <= a_sample_q;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && a_emit_q) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && a_emit_q) begin
      out_row_q  <= a_row_q - 1'b1;
      out_col_q  <= a_col_q - 1'b1;
      out_mean_q <= MEAN_BITS'(sum);
      out_last_q <= a_last_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_W'({out_mean_q, out_col_q, out_row_q});
  assign m_axis_tlast_o  = out_last_q;

endmodule

[hw/rtl/ens_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Used for the line stores of the stencil; no dependencies.
module ens_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [ADDR_BITS-1:0] waddr_i,
  input  logic [WIDTH-1:0]     wdata_i,
  input  logic                 re_i,
  input  logic [ADDR_BITS-1:0] raddr_i,
  output logic [WIDTH-1:0]     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/ens_checker.sv]
// Port-level checks for the eight-neighbour mean stencil, bound to its top.
// Depends on ens_pkg and eight_neighbour_mean_stencil.
module ens_checker
  import ens_pkg::*;
#(
  parameter int unsigned MAX_WIDTH   = 4096,
  parameter int unsigned SAMPLE_BITS = 16,
  localparam int unsigned COL_BITS = $clog2(MAX_WIDTH),
  localparam int unsigned OUT_BITS = ROW_BITS + COL_BITS + MEAN_BITS,
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     s_axis_tvalid_i,
  input logic                     s_axis_tready_o,
  input logic                     m_axis_tvalid_o,
  input logic                     m_axis_tready_i,
  input logic [OUT_W-1:0]         m_axis_tdata_o,
  input logic                     m_axis_tlast_o,
  input logic                     cfg_valid_i,
  input logic                     cfg_ready_o
);

  logic [ROW_BITS-1:0] res_row;
  logic [COL_BITS-1:0] res_col;

  assign res_row = m_axis_tdata_o[ROW_BITS-1:0];
  assign res_col = m_axis_tdata_o[ROW_BITS+COL_BITS-1:ROW_BITS];

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("result word changed while stalled");

  // Results never fall on the first row or the first column
  a_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (res_row != '0) && (res_col != '0))
    else $error("result on an outer row or column");

  // With the output register empty the input side never stalls
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty output");

  // Source check on a rise of valid; always met, since valid was low before
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(s_axis_tready_o) || $past(s_axis_tvalid_i)
      || !$past(m_axis_tvalid_o))
    else $error("result appeared without a source");

  // The config port never stalls
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config write stalled");

endmodule

bind eight_neighbour_mean_stencil ens_checker #(
  .MAX_WIDTH   (MAX_WIDTH),
  .SAMPLE_BITS (SAMPLE_BITS)
) u_ens_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .cfg_valid_i     (cfg_valid_i),
  .cfg_ready_o     (cfg_ready_o)
);

[bench/tb_eight_neighbour_mean_stencil.sv]
`timescale 1ns / 1ps
// Self-checking bench for eight_neighbour_mean_stencil: streams raster frames of
// many sizes through the block and checks every interior neighbour sum word.
// Depends on ens_pkg and the stencil RTL.
module tb_eight_neighbour_mean_stencil;
  import ens_pkg::*;

  localparam int unsigned MAX_W          = 4096;
  localparam int unsigned MAX_H          = 65535;
  localparam int unsigned SAMPLE_W       = 16;
  localparam int unsigned COL_W          = 12;
  localparam int unsigned OUT_W          = 48;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 8'hA5;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned ITEMS_PER_MODE = 300;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned WIDE_RUN       = 64;

  typedef struct packed {
    logic [ROW_BITS-1:0]  row;
    logic [COL_W-1:0]     col;
    logic [MEAN_BITS-1:0] sum;
    logic                 last;
  } window_sum_t;

  logic                     clk_i     = 1'b0;
  logic                     rst_ni    = 1'b0;
  logic                     s_valid   = 1'b0;
  logic                     s_ready;
  logic [SAMPLE_W-1:0]      s_data    = '0;
  logic                     m_valid;
  logic                     m_ready   = 1'b0;
  logic [OUT_W-1:0]         m_data;
  logic                     m_last;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

  int unsigned send_idle_pct = 6;
  int unsigned recv_idle_pct = 82;
  int unsigned error_count   = 0;

  // Mirror of the block: line stores, window, raster position, registers
  logic [SAMPLE_W-1:0] upper_row  [MAX_W];
  logic [SAMPLE_W-1:0] middle_row [MAX_W];
  logic [SAMPLE_W-1:0] win        [6];
  int unsigned row_pos    = 0;
  int unsigned col_pos    = 0;
  int unsigned width_reg  = FRAME_WIDTH_RST;
  int unsigned height_reg = FRAME_HEIGHT_RST;

  logic [SAMPLE_W-1:0] raster_q[$];
  window_sum_t         expected_sums[$];

  eight_neighbour_mean_stencil u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int unsigned clamp_side(int unsigned raw, int unsigned hi);
    if (raw < MIN_SIDE) return MIN_SIDE;
    if (raw > hi) return hi;
    return raw;
  endfunction

  function automatic logic [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Take one sample into the mirror and queue the window sum it completes
  task automatic advance_raster(input logic [SAMPLE_W-1:0] bot);
    int unsigned w;
    int unsigned h;
    int unsigned idx;
    int unsigned total;
    logic [SAMPLE_W-1:0] top;
    logic [SAMPLE_W-1:0] mid;
    window_sum_t res;
    w   = clamp_side(width_reg, MAX_W);
    h   = clamp_side(height_reg, MAX_H);
    idx = (col_pos < MAX_W) ? col_pos : 0;
    top = upper_row[idx];
    mid = middle_row[idx];
    if (row_pos >= 2 && col_pos >= 2) begin
      // centre sits in win[4] and stays out of the sum
      total = win[0] + win[1] + win[2] + win[3] + win[5] + top + mid + bot;
      res.row  = ROW_BITS'(row_pos - 1);
      res.col  = COL_W'(col_pos - 1);
      res.sum  = MEAN_BITS'(total);
      res.last = (row_pos >= h - 1) && (col_pos >= w - 1);
      expected_sums.push_back(res);
    end
    upper_row[idx]  = mid;
    middle_row[idx] = bot;
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = top;
    win[4] = mid;
    win[5] = bot;
    if (col_pos >= w - 1) begin
      col_pos = 0;
      row_pos = (row_pos >= h - 1) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
  endtask

  task automatic note_error(input string what, input window_sum_t want, input window_sum_t got);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("%0t %s: exp row %0d col %0d sum %0d last %0b, got row %0d col %0d sum %0d last %0b",
               $realtime, what, want.row, want.col, want.sum, want.last,
               got.row, got.col, got.sum, got.last);
  endtask

  // Sample driver: hold the word until accepted, idle at random between words
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else begin
      if (s_valid && s_ready) advance_raster(s_data);
      if (!s_valid || s_ready) begin
        if (raster_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          s_valid <= 1'b1;
          s_data  <= raster_q.pop_front();
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random backpressure
  always @(posedge clk_i) begin : result_monitor
    window_sum_t got;
    window_sum_t want;
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      if (m_valid && m_ready) begin
        got.row  = m_data[ROW_BITS-1:0];
        got.col  = m_data[ROW_BITS +: COL_W];
        got.sum  = m_data[ROW_BITS + COL_W +: MEAN_BITS];
        got.last = m_last;
        if (expected_sums.size() == 0) begin
          note_error("unexpected word", '0, got);
        end else begin
          want = expected_sums.pop_front();
          if (got !== want) note_error("mismatch", want, got);
        end
      end
      m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Wait until every queued sample is in and every expected word is out
  task automatic drain();
    while (raster_q.size() != 0 || s_valid || expected_sums.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    drain();
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_FRAME_WIDTH) begin
      width_reg = val[FW_BITS-1:0];
      row_pos   = 0;
      col_pos   = 0;
    end else if (idx == REG_FRAME_HEIGHT) begin
      height_reg = val;
      row_pos    = 0;
      col_pos    = 0;
    end
  endtask

  // New small geometry, a few whole frames, sometimes a frame cut short
  task automatic random_phase(inout int unsigned pushed);
    int unsigned raw_w;
    int unsigned raw_h;
    int unsigned n;
    raw_w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
    raw_h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
    if ($urandom_range(0, 1) == 0) begin
      write_reg(REG_FRAME_WIDTH, CFG_DATA_BITS'(raw_w));
      write_reg(REG_FRAME_HEIGHT, CFG_DATA_BITS'(raw_h));
    end else begin
      write_reg(REG_FRAME_HEIGHT, CFG_DATA_BITS'(raw_h));
      write_reg(REG_FRAME_WIDTH, CFG_DATA_BITS'(raw_w));
    end
    n = $urandom_range(1, 3) * clamp_side(width_reg, MAX_W) * clamp_side(height_reg, MAX_H);
    if ($urandom_range(0, 3) == 0)
      n += $urandom_range(1, clamp_side(width_reg, MAX_W) * clamp_side(height_reg, MAX_H) - 1);
    repeat (n) raster_q.push_back(random_sample());
    pushed += n;
  endtask

  initial begin : stimulus
    int unsigned pushed;
    for (int i = 0; i < MAX_W; i++) begin
      upper_row[i]  = '0;
      middle_row[i] = '0;
    end
    for (int i = 0; i < 6; i++) win[i] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Smallest frame, sizes below the minimum clamp to three
    write_reg(REG_FRAME_WIDTH, '0);
    write_reg(REG_FRAME_HEIGHT, '0);
    repeat (9) raster_q.push_back('1);
    for (int i = 0; i < 9; i++) raster_q.push_back((i == 4) ? '1 : '0);
    for (int i = 0; i < 9; i++) raster_q.push_back((i == 4) ? '0 : '1);

    pushed = 0;
    while (pushed < ITEMS_PER_MODE) random_phase(pushed);

    send_idle_pct = 82;
    recv_idle_pct = 6;
    // Tallest frame, cut short; a spare index write must not restart it
    write_reg(REG_FRAME_WIDTH, CFG_DATA_BITS'(MIN_SIDE));
    write_reg(REG_FRAME_HEIGHT, '1);
    repeat (120) raster_q.push_back(random_sample());
    write_reg(REG_SPARE, CFG_DATA_BITS'($urandom));
    repeat (30) raster_q.push_back(random_sample());
    pushed += 150;
    while (pushed < 2 * ITEMS_PER_MODE) random_phase(pushed);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (pushed < 3 * ITEMS_PER_MODE) random_phase(pushed);

    // Widest frame: all-ones width clamps to the line store depth; only part
    // of the first row goes in, so no word is due
    write_reg(REG_FRAME_WIDTH, '1);
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_BITS'(MIN_SIDE));
    repeat (WIDE_RUN) raster_q.push_back(random_sample());

    drain();
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
